// File: design/gbn_pkg.sv
package gbn_pkg;

	localparam int DEF_MAX_WINDOW  = 32;
	localparam int DEF_INDEX_WIDTH = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int FIELD_WIDTH = 16;
	localparam int WINDOW_REG_WIDTH = 6;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [FIELD_WIDTH-1:0] TIMER_MAX = {FIELD_WIDTH{1'b1}};

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_ACK   = 2'd2;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PACKET_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_SIZE   = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS = 2'd2;

	localparam logic [FIELD_WIDTH-1:0]      RST_PACKET_COUNT  = 16'd1;
	localparam logic [WINDOW_REG_WIDTH-1:0] RST_WINDOW_SIZE   = 6'd10;
	localparam logic [FIELD_WIDTH-1:0]      RST_TIMEOUT_TICKS = 16'd500;

	// per-item status that rides along with a burst of sends
	typedef struct packed {
		logic retx;
		logic bad;
		logic done;
	} gbn_flags_t;

endpackage

// File: design/gbn_front.sv
module gbn_front #(
	parameter int MAX_WINDOW  = gbn_pkg::DEF_MAX_WINDOW,
	parameter int INDEX_WIDTH = gbn_pkg::DEF_INDEX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [gbn_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [gbn_pkg::FIELD_WIDTH-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            operation,
	input  logic [gbn_pkg::FIELD_WIDTH-1:0]       ack_index,
	input  logic                                  q_full,
	output logic                                  push,
	output logic [$clog2(MAX_WINDOW + 1)-1:0]     job_count,
	output logic [INDEX_WIDTH-1:0]                job_first,
	output gbn_pkg::gbn_flags_t                   job_flags
);
	import gbn_pkg::*;

	localparam int IW = INDEX_WIDTH;
	localparam int NW = $clog2(MAX_WINDOW + 1);
	localparam int WW = (IW + 1 > NW) ? IW + 1 : NW;
	localparam logic [WW-1:0] MAXW = WW'(MAX_WINDOW);
	localparam logic [32:0] IDX_MASK = (33'd1 << IW) - 33'd1;

	logic [FIELD_WIDTH-1:0]      pc_q;
	logic [WINDOW_REG_WIDTH-1:0] ws_q;
	logic [FIELD_WIDTH-1:0]      tt_q;

	logic [IW-1:0]          base_q, nts_q;
	logic [FIELD_WIDTH-1:0] tc_q;
	logic                   run_q, act_q;

	logic [IW-1:0]          base_d, nts_d;
	logic [FIELD_WIDTH-1:0] tc_d;
	logic                   run_d, act_d;

	logic [IW-1:0]          ec;
	logic [WW-1:0]          ew;
	logic [FIELD_WIDTH-1:0] tlim;
	logic [IW-1:0]          ack_w;
	logic [32:0]            pc_ext;
	logic                   accept;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign push     = accept;
	assign ack_w    = IW'(ack_index);

	// effective count, window and timeout
	always_comb begin
		pc_ext = {17'd0, pc_q};
		ec = (pc_ext > IDX_MASK) ? IW'(IDX_MASK) : IW'(pc_ext);
		if (ec == '0) ec = IW'(1);
		if (ws_q == '0) ew = WW'(1);
		else if (WW'(ws_q) > MAXW) ew = MAXW;
		else ew = WW'(ws_q);
		tlim = (tt_q == '0) ? FIELD_WIDTH'(1) : tt_q;
	end

	always_comb begin
		logic          fill;
		logic [WW-1:0] lim, d1, d2, m;
		base_d = base_q;
		nts_d = nts_q;
		tc_d = tc_q;
		run_d = run_q;
		act_d = act_q;
		fill = 1'b0;
		lim = '0;
		d1 = '0;
		d2 = '0;
		m = '0;
		job_count = '0;
		job_first = '0;
		job_flags = '0;
		if (act_d && base_d >= ec) begin
			act_d = 1'b0;
			run_d = 1'b0;
			tc_d = '0;
		end
		unique case (operation)
			OP_START: begin
				base_d = '0;
				nts_d = '0;
				tc_d = '0;
				run_d = 1'b0;
				act_d = 1'b1;
				fill = 1'b1;
			end
			OP_TICK: begin
				if (act_d && run_d) begin
					if (tc_d != TIMER_MAX) tc_d = tc_d + FIELD_WIDTH'(1);
					if (tc_d >= tlim) begin
						// resend everything in flight
						d1 = WW'(nts_d - base_d);
						m = (d1 > MAXW) ? MAXW : d1;
						job_first = base_d;
						job_count = NW'(m);
						job_flags.retx = 1'b1;
						tc_d = '0;
						run_d = 1'b1;
					end
				end
			end
			OP_ACK: begin
				if (act_d) begin
					if (ack_w >= nts_d) begin
						job_flags.bad = 1'b1;
					end else if (ack_w >= base_d) begin
						base_d = ack_w + IW'(1);
						tc_d = '0;
						run_d = 1'b1;
						if (base_d >= ec) begin
							act_d = 1'b0;
							run_d = 1'b0;
							tc_d = '0;
						end else begin
							fill = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		if (fill) begin
			lim = WW'(base_d) + ew;
			if (nts_d < ec && WW'(nts_d) < lim) begin
				d1 = WW'(ec - nts_d);
				d2 = lim - WW'(nts_d);
				m = (d1 < d2) ? d1 : d2;
				if (m > MAXW) m = MAXW;
				job_first = nts_d;
				job_count = NW'(m);
				if (nts_d == base_d) begin
					tc_d = '0;
					run_d = 1'b1;
				end
				nts_d = nts_d + IW'(m);
			end
		end
		if (act_d && base_d >= ec) begin
			act_d = 1'b0;
			run_d = 1'b0;
			tc_d = '0;
		end
		job_flags.done = (base_d >= ec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= RST_PACKET_COUNT;
			ws_q <= RST_WINDOW_SIZE;
			tt_q <= RST_TIMEOUT_TICKS;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PACKET_COUNT:  pc_q <= cfg_data;
				CFG_WINDOW_SIZE:   ws_q <= cfg_data[WINDOW_REG_WIDTH-1:0];
				CFG_TIMEOUT_TICKS: tt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			nts_q <= '0;
			tc_q <= '0;
			run_q <= 1'b0;
			act_q <= 1'b0;
		end else if (accept) begin
			base_q <= base_d;
			nts_q <= nts_d;
			tc_q <= tc_d;
			run_q <= run_d;
			act_q <= act_d;
		end
	end

endmodule

// File: design/gbn_queue.sv
module gbn_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = gbn_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// File: design/gbn_back.sv
module gbn_back #(
	parameter int MAX_WINDOW  = gbn_pkg::DEF_MAX_WINDOW,
	parameter int INDEX_WIDTH = gbn_pkg::DEF_INDEX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  logic [$clog2(MAX_WINDOW + 1)-1:0] head_count,
	input  logic [INDEX_WIDTH-1:0]            head_first,
	input  gbn_pkg::gbn_flags_t               head_flags,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              send_valid,
	output logic [gbn_pkg::FIELD_WIDTH-1:0]   packet_index,
	output logic                              is_retransmit,
	output logic                              bad_ack,
	output logic                              transfer_done,
	output logic                              last
);
	import gbn_pkg::*;

	localparam int IW = INDEX_WIDTH;
	localparam int NW = $clog2(MAX_WINDOW + 1);

	logic [NW-1:0] idx_q;
	logic          load, item_end, has_send;
	logic          valid_q, send_q, retx_q, bad_q, done_q, last_q;
	logic [FIELD_WIDTH-1:0] index_q;

	assign has_send = (head_count != '0);
	assign load     = head_valid && (!valid_q || !out_stall);
	assign item_end = !has_send || (idx_q == head_count - NW'(1));
	assign pop      = load && item_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (!valid_q || !out_stall) valid_q <= head_valid;
			if (load) idx_q <= item_end ? '0 : idx_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			send_q <= has_send;
			index_q <= has_send ? FIELD_WIDTH'(head_first + IW'(idx_q)) : '0;
			retx_q <= has_send && head_flags.retx;
			bad_q <= head_flags.bad;
			done_q <= head_flags.done;
			last_q <= item_end;
		end
	end

	assign out_valid     = valid_q;
	assign send_valid    = send_q;
	assign packet_index  = index_q;
	assign is_retransmit = retx_q;
	assign bad_ack       = bad_q;
	assign transfer_done = done_q;
	assign last          = last_q;

endmodule

// File: design/go_back_n_sender_window_core.sv
// channel | handshake                   | payload
// --------+-----------------------------+------------------------------------------
// in      | in_valid / in_stall         | operation, ack_index
// out     | out_valid / out_stall       | send_valid, packet_index, is_retransmit,
//         |                             | bad_ack, transfer_done, last
// cfg     | cfg_write                   | cfg_index, cfg_data
//
// the front end updates the window state and takes one item per cycle while the
// two-entry job queue has room; results pass through the job queue and the output register
// the back end emits one result per cycle while out_stall is low; an item gives max(sends, 1)
// results there: up to MAX_WINDOW for a full window fill or a timeout resend
// reset clears the window state, the queue and the output valid flag; config takes reset values
// out_stall holds the output register and backs up through the queue to in_stall
module go_back_n_sender_window_core #(
	parameter int MAX_WINDOW  = gbn_pkg::DEF_MAX_WINDOW,
	parameter int INDEX_WIDTH = gbn_pkg::DEF_INDEX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gbn_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [gbn_pkg::FIELD_WIDTH-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [gbn_pkg::FIELD_WIDTH-1:0]     ack_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                send_valid,
	output logic [gbn_pkg::FIELD_WIDTH-1:0]     packet_index,
	output logic                                is_retransmit,
	output logic                                bad_ack,
	output logic                                transfer_done,
	output logic                                last
);
	import gbn_pkg::*;

	localparam int NW = $clog2(MAX_WINDOW + 1);
	localparam int JW = NW + INDEX_WIDTH + $bits(gbn_flags_t);

	logic                   q_full, push, pop, head_valid;
	logic [NW-1:0]          job_count, head_count;
	logic [INDEX_WIDTH-1:0] job_first, head_first;
	gbn_flags_t             job_flags, head_flags;
	logic [JW-1:0]          head_data;

	gbn_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.ack_index(ack_index),
		.q_full(q_full),
		.push(push),
		.job_count(job_count),
		.job_first(job_first),
		.job_flags(job_flags)
	);

	gbn_queue #(
		.WIDTH(JW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({job_count, job_first, job_flags}),
		.pop(pop),
		.full(q_full),
		.head_valid(head_valid),
		.head_data(head_data)
	);

	assign {head_count, head_first, head_flags} = head_data;

	gbn_back #(
		.MAX_WINDOW(MAX_WINDOW),
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_count(head_count),
		.head_first(head_first),
		.head_flags(head_flags),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_valid(send_valid),
		.packet_index(packet_index),
		.is_retransmit(is_retransmit),
		.bad_ack(bad_ack),
		.transfer_done(transfer_done),
		.last(last)
	);

endmodule

// File: design/gbn_checker.sv
module gbn_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            send_valid,
	input logic [gbn_pkg::FIELD_WIDTH-1:0] packet_index,
	input logic                            is_retransmit,
	input logic                            bad_ack,
	input logic                            last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(packet_index) && $stable(last))
		else $error("stalled output item changed");

	// an item with no send is a lone, zeroed result
	a_no_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |-> last && packet_index == '0 && !is_retransmit)
		else $error("empty result not a lone zeroed item");

	a_bad_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_ack |-> !send_valid && last)
		else $error("rejected acknowledgement caused a send");

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (.*);
